// File: hw/rtl/interrupt_rate_limit_quarantine_macros.svh
// Assertion macros for the interrupt rate limiter.
// Used by the top level; needs i_clk and i_rst_n in scope.
`ifndef INTERRUPT_RATE_LIMIT_QUARANTINE_MACROS_SVH
`define INTERRUPT_RATE_LIMIT_QUARANTINE_MACROS_SVH

// same-cycle implication
`define IRLQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed: same cycle");

// next-cycle implication
`define IRLQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed: next cycle");

`endif

// File: hw/rtl/irlq_pkg.sv
// Shared types and codes for the interrupt rate limiter.
// No dependencies.
package irlq_pkg;

    localparam logic       REQ_IRQ = 1'b0;
    localparam logic       REQ_CFG = 1'b1;

    localparam logic [1:0] VERDICT_ALLOW      = 2'd0;
    localparam logic [1:0] VERDICT_DENY       = 2'd1;
    localparam logic [1:0] VERDICT_QUARANTINE = 2'd2;

    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  source_id;
        logic [31:0] now_cycle;
        logic [15:0] limit_value;
        logic [31:0] window_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] verdict;
        logic [7:0] source_echo;
    } t_out_item;

    typedef struct packed {
        logic load_item;
        logic cfg_wr;
        logic judge;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// File: hw/rtl/irlq_ctrl.sv
// Controller FSM for the interrupt rate limiter.
// Depends on irlq_pkg; drives irlq_dp through t_dp_cmd.
module irlq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_req_type,
    input  irlq_pkg::t_dp_sts i_sts,
    output logic              o_in_stall,
    output irlq_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CFG   = 3'b010,
        S_JUDGE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_req_type == irlq_pkg::REQ_CFG) ? S_CFG : S_JUDGE;
                end
            end
            S_CFG: begin
                n_state = S_IDLE;
            end
            S_JUDGE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_cmd.load_item = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.cfg_wr    = (r_state == S_CFG);
    assign o_cmd.judge     = (r_state == S_JUDGE);

endmodule

// File: hw/rtl/irlq_dp.sv
// Datapath for the interrupt rate limiter: per-source tables, verdict
// logic and output register. Depends on irlq_pkg; commanded by irlq_ctrl.
module irlq_dp #(
    parameter int NUM_SOURCES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  irlq_pkg::t_in_item  i_in,
    input  irlq_pkg::t_dp_cmd   i_cmd,
    input  logic                i_out_stall,
    output irlq_pkg::t_dp_sts   o_sts,
    output logic                o_out_valid,
    output irlq_pkg::t_out_item o_out
);

    localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

    typedef struct packed {
        logic [15:0] limit;
        logic [31:0] window;
    } t_cfg_ent;

    typedef struct packed {
        logic [16:0] count;
        logic [31:0] start;
    } t_st_ent;

    t_cfg_ent mem_cfg [NUM_SOURCES];
    t_st_ent  mem_st  [NUM_SOURCES];

    logic [NUM_SOURCES-1:0] r_cfg_vld;
    logic [NUM_SOURCES-1:0] r_quar;

    irlq_pkg::t_in_item  r_item;
    t_cfg_ent            r_cfg_rd;
    t_st_ent             r_st_rd;
    logic                r_cfg_vq;
    logic                r_quar_q;
    logic                r_out_vld;
    irlq_pkg::t_out_item r_out;

    logic [IDX_W-1:0] w_rd_addr;
    logic [IDX_W-1:0] w_addr;
    logic             w_in_range;
    logic             w_commit;
    logic             w_cfg_we;
    logic [15:0]      w_lim;
    logic [31:0]      w_win;
    logic [16:0]      w_cnt;
    logic [31:0]      w_start;
    logic [31:0]      w_elapsed;
    logic             w_limited;
    logic             w_expired;
    logic [16:0]      w_base;
    logic [16:0]      w_new_cnt;
    logic [31:0]      w_new_start;
    logic             w_over;
    logic             w_st_we;
    logic [1:0]       w_verdict;

    assign w_rd_addr  = i_in.source_id[IDX_W-1:0];
    assign w_addr     = r_item.source_id[IDX_W-1:0];
    assign w_in_range = ({1'b0, r_item.source_id} < 9'(NUM_SOURCES));

    assign o_sts.out_free = !r_out_vld || !i_out_stall;
    assign w_commit       = i_cmd.judge && o_sts.out_free;
    assign w_cfg_we       = i_cmd.cfg_wr && w_in_range;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item   <= i_in;
            r_cfg_rd <= mem_cfg[w_rd_addr];
            r_st_rd  <= mem_st[w_rd_addr];
            r_cfg_vq <= r_cfg_vld[w_rd_addr];
            r_quar_q <= r_quar[w_rd_addr];
        end
    end

    // unwritten entries read as zero through the valid bits; the count and
    // window start of an entry are zeroed on its first configure
    assign w_lim   = r_cfg_vq ? r_cfg_rd.limit  : 16'd0;
    assign w_win   = r_cfg_vq ? r_cfg_rd.window : 32'd0;
    assign w_cnt   = r_cfg_vq ? r_st_rd.count   : 17'd0;
    assign w_start = r_cfg_vq ? r_st_rd.start   : 32'd0;

    assign w_limited   = (w_lim != 16'd0) && (w_win != 32'd0);
    assign w_elapsed   = r_item.now_cycle - w_start;
    assign w_expired   = (w_elapsed >= w_win);
    assign w_base      = w_expired ? 17'd0 : w_cnt;
    assign w_new_cnt   = (w_base == irlq_pkg::COUNT_MAX) ? w_base : w_base + 17'd1;
    assign w_new_start = w_expired ? r_item.now_cycle : w_start;
    assign w_over      = (w_new_cnt > {1'b0, w_lim});
    assign w_st_we     = w_commit && w_in_range && !r_quar_q && w_limited;

    always_comb begin
        if (!w_in_range) begin
            w_verdict = irlq_pkg::VERDICT_ALLOW;
        end else if (r_quar_q) begin
            w_verdict = irlq_pkg::VERDICT_DENY;
        end else if (w_limited && w_over) begin
            w_verdict = irlq_pkg::VERDICT_QUARANTINE;
        end else begin
            w_verdict = irlq_pkg::VERDICT_ALLOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cfg_we) begin
            mem_cfg[w_addr] <= '{limit: r_item.limit_value, window: r_item.window_value};
        end
        if (w_st_we) begin
            mem_st[w_addr] <= '{count: w_new_cnt, start: w_new_start};
        end else if (w_cfg_we && !r_cfg_vq) begin
            mem_st[w_addr] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_vld <= '0;
            r_quar    <= '0;
        end else begin
            if (w_cfg_we) begin
                r_cfg_vld[w_addr] <= 1'b1;
            end
            if (w_st_we && w_over) begin
                r_quar[w_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_commit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out.verdict     <= w_verdict;
            r_out.source_echo <= r_item.source_id;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

// File: hw/rtl/interrupt_rate_limit_quarantine.sv
// Per-source interrupt rate limiter with sticky quarantine.
// An accepted beat is registered with its table reads; its judge step registers
// the verdict beat. No new beat is accepted until its table write or judge step
// ends; the judge step waits while an earlier verdict is stalled at the output.
// Reset: synchronous, active low; clears all per-source tables at once
// through valid and quarantine flops, so no clearing pass is needed.
`include "interrupt_rate_limit_quarantine_macros.svh"

module interrupt_rate_limit_quarantine #(
    parameter int NUM_SOURCES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  irlq_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output irlq_pkg::t_out_item o_out
);

    irlq_pkg::t_dp_cmd w_cmd;
    irlq_pkg::t_dp_sts w_sts;

    irlq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in.req_type),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    irlq_dp #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    `IRLQ_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    `IRLQ_ASSERT_NOW(a_judge_while_busy, w_cmd.judge || w_cmd.cfg_wr, o_in_stall)
    `IRLQ_ASSERT_NEXT(a_verdict_after_judge, w_cmd.judge && w_sts.out_free, o_out_valid)
    `IRLQ_ASSERT_NEXT(a_cfg_no_result, w_cmd.cfg_wr && !o_out_valid, !o_out_valid)

endmodule

// File: dv/irlq_verdict_checker.sv
`timescale 1ns / 1ps
// Verdict checker for interrupt_rate_limit_quarantine: watches both beat channels,
// keeps its own per-source tables and compares every verdict beat in order.
// Depends on irlq_pkg.
module irlq_verdict_checker #(
    parameter int NUM_SOURCES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  irlq_pkg::t_in_item  i_in,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  irlq_pkg::t_out_item i_out,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked,
    output int                  o_denials,
    output int                  o_quarantines
);

    logic        quarantined [NUM_SOURCES];
    logic [16:0] event_count [NUM_SOURCES];
    logic [31:0] window_start[NUM_SOURCES];
    logic [15:0] src_limit   [NUM_SOURCES];
    logic [31:0] src_window  [NUM_SOURCES];

    irlq_pkg::t_out_item verdict_queue[$];

    task automatic report(input string what, input logic [7:0] src, input int got_v,
                          input int want_v);
        $display("MISMATCH @%0t: %s src=%0d got=%0d exp=%0d", $time, what, src, got_v, want_v);
        o_fail_count++;
    endtask

    function automatic logic [1:0] judge_interrupt(input logic [7:0] src,
                                                   input logic [31:0] now);
        logic [16:0] cnt;
        if (src >= NUM_SOURCES) return irlq_pkg::VERDICT_ALLOW;
        if (quarantined[src]) return irlq_pkg::VERDICT_DENY;
        if (src_limit[src] == '0 || src_window[src] == '0) return irlq_pkg::VERDICT_ALLOW;
        // fixed window, modular elapsed time
        if (now - window_start[src] >= src_window[src]) begin
            event_count[src]  = '0;
            window_start[src] = now;
        end
        cnt = event_count[src];
        if (cnt != irlq_pkg::COUNT_MAX) cnt = cnt + 17'd1;
        event_count[src] = cnt;
        if (cnt > {1'b0, src_limit[src]}) begin
            quarantined[src] = 1'b1;
            return irlq_pkg::VERDICT_QUARANTINE;
        end
        return irlq_pkg::VERDICT_ALLOW;
    endfunction

    always @(posedge i_clk) begin : watch
        irlq_pkg::t_out_item got;
        irlq_pkg::t_out_item want;
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SOURCES; s++) begin
                quarantined[s]  = 1'b0;
                event_count[s]  = '0;
                window_start[s] = '0;
                src_limit[s]    = '0;
                src_window[s]   = '0;
            end
            verdict_queue.delete();
            o_pending = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = i_out;
                if (verdict_queue.size() == 0) begin
                    report("verdict beat with nothing expected", got.source_echo,
                           got.verdict, -1);
                end else begin
                    want = verdict_queue.pop_front();
                    o_checked++;
                    if (got.verdict != want.verdict)
                        report("verdict", want.source_echo, got.verdict, want.verdict);
                    if (got.source_echo != want.source_echo)
                        report("source_echo", want.source_echo, got.source_echo,
                               want.source_echo);
                    if (want.verdict == irlq_pkg::VERDICT_DENY) o_denials++;
                    if (want.verdict == irlq_pkg::VERDICT_QUARANTINE) o_quarantines++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in.req_type == irlq_pkg::REQ_CFG) begin
                    if (i_in.source_id < NUM_SOURCES) begin
                        src_limit[i_in.source_id]  = i_in.limit_value;
                        src_window[i_in.source_id] = i_in.window_value;
                    end
                end else begin
                    want.verdict     = judge_interrupt(i_in.source_id, i_in.now_cycle);
                    want.source_echo = i_in.source_id;
                    verdict_queue.push_back(want);
                end
            end
            o_pending = verdict_queue.size();
        end
    end

endmodule

// File: dv/interrupt_rate_limit_quarantine_test.sv
`timescale 1ns / 1ps
// Top of the interrupt_rate_limit_quarantine testbench: clock, reset, beat stimulus
// and verdict. Depends on irlq_pkg, the block and irlq_verdict_checker.
module interrupt_rate_limit_quarantine_test;

    localparam int NUM_SOURCES  = 256;
    localparam int PHASES       = 6;
    localparam int PHASE_BEATS  = 275;
    localparam int CYCLE_LIMIT  = 120000;
    localparam int DRAIN_CYCLES = 8;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    irlq_pkg::t_in_item  in_beat   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    irlq_pkg::t_out_item out_beat;
    logic                no_idle   = 1'b0;

    int fail_count, pending, checked, denials, quarantines;
    int cycle_count, cfg_sent, irq_sent;
    logic [31:0] clock_now;
    logic [7:0]  src_pool[16];

    interrupt_rate_limit_quarantine #(.NUM_SOURCES(NUM_SOURCES)) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_beat),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_beat)
    );

    irlq_verdict_checker #(.NUM_SOURCES(NUM_SOURCES)) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_beat),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_beat),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_denials    (denials),
        .o_quarantines(quarantines)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_stall <= !no_idle && ($urandom_range(0, 99) < 33);
    end

    function automatic irlq_pkg::t_in_item cfg_beat(input logic [7:0] src,
                                                    input logic [15:0] lim,
                                                    input logic [31:0] win);
        irlq_pkg::t_in_item b;
        b.req_type     = irlq_pkg::REQ_CFG;
        b.source_id    = src;
        b.now_cycle    = $urandom;
        b.limit_value  = lim;
        b.window_value = win;
        return b;
    endfunction

    function automatic irlq_pkg::t_in_item irq_beat(input logic [7:0] src,
                                                    input logic [31:0] now);
        irlq_pkg::t_in_item b;
        b.req_type     = irlq_pkg::REQ_IRQ;
        b.source_id    = src;
        b.now_cycle    = now;
        b.limit_value  = 16'($urandom);
        b.window_value = $urandom;
        return b;
    endfunction

    // mostly a small pool of sources with tight limits and windows, so that
    // windows restart and sources get quarantined; the rest is anything
    function automatic irlq_pkg::t_in_item random_beat();
        logic [7:0]  src;
        logic [15:0] lim;
        logic [31:0] win;
        int          pick;
        src = ($urandom_range(0, 99) < 80) ? src_pool[$urandom_range(0, 15)] : 8'($urandom);
        if ($urandom_range(0, 99) < 15) begin
            pick = $urandom_range(0, 9);
            lim  = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom)
                                                     : 16'($urandom_range(1, 6));
            pick = $urandom_range(0, 9);
            win  = (pick == 0) ? 32'd0 : (pick == 1) ? 32'($urandom)
                                                     : 32'($urandom_range(4, 300));
            return cfg_beat(src, lim, win);
        end
        if ($urandom_range(0, 99) < 2) clock_now = $urandom;
        else clock_now = clock_now + 32'($urandom_range(0, 6));
        return irq_beat(src, clock_now);
    endfunction

    task automatic send_beat(input irlq_pkg::t_in_item beat);
        while (!no_idle && $urandom_range(0, 99) < 33) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        if (beat.req_type == irlq_pkg::REQ_CFG) cfg_sent++;
        else irq_sent++;
    endtask

    task automatic wait_idle();
        do @(negedge clk); while (pending != 0);
    endtask

    initial begin
        clock_now = 32'd0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // unconfigured source is unlimited
        send_beat(irq_beat(8'd0, 32'd5));
        // limit 2: allow, allow, quarantine, then deny, sticky across reconfigure
        send_beat(cfg_beat(8'd1, 16'd2, 32'd100));
        send_beat(irq_beat(8'd1, 32'd10));
        send_beat(irq_beat(8'd1, 32'd20));
        send_beat(irq_beat(8'd1, 32'd30));
        send_beat(irq_beat(8'd1, 32'd500));
        send_beat(cfg_beat(8'd1, 16'd0, 32'd0));
        send_beat(irq_beat(8'd1, 32'd600));
        // zero window or zero limit
        send_beat(cfg_beat(8'd2, 16'd1, 32'd0));
        send_beat(irq_beat(8'd2, 32'd7));
        send_beat(irq_beat(8'd2, 32'd7));
        send_beat(cfg_beat(8'd3, 16'd0, 32'd50));
        send_beat(irq_beat(8'd3, 32'd9));
        // window restart exactly at the window length
        send_beat(cfg_beat(8'd4, 16'd1, 32'd50));
        send_beat(irq_beat(8'd4, 32'd100));
        send_beat(irq_beat(8'd4, 32'd150));
        send_beat(irq_beat(8'd4, 32'd151));
        // elapsed time across the 32-bit wrap
        send_beat(cfg_beat(8'd5, 16'd1, 32'd16));
        send_beat(irq_beat(8'd5, 32'hFFFF_FFF8));
        send_beat(irq_beat(8'd5, 32'h0000_0004));
        // field extremes
        send_beat(cfg_beat(8'd255, 16'hFFFF, 32'hFFFF_FFFF));
        send_beat(irq_beat(8'd255, 32'hFFFF_FFFF));
        send_beat(cfg_beat(8'd254, 16'd1, 32'd1));
        send_beat(irq_beat(8'd254, 32'd0));
        send_beat(irq_beat(8'd254, 32'd0));
        in_valid <= 1'b0;
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            no_idle <= (p == 2);
            foreach (src_pool[i]) src_pool[i] = 8'($urandom);
            repeat (PHASE_BEATS) begin
                if ($urandom_range(0, 99) < 5) src_pool[$urandom_range(0, 15)] = 8'($urandom);
                send_beat(random_beat());
            end
            in_valid <= 1'b0;
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Covered %0d interrupt and %0d configure beats; %0d verdicts checked",
                 irq_sent, cfg_sent, checked);
        $display("including %0d denials and %0d quarantines, with stalls on both sides",
                 denials, quarantines);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/irlq_pkg.sv
hw/rtl/irlq_ctrl.sv
hw/rtl/irlq_dp.sv
hw/rtl/interrupt_rate_limit_quarantine.sv
dv/irlq_verdict_checker.sv
dv/interrupt_rate_limit_quarantine_test.sv
